// ===== hw/rtl/kee_pkg.sv =====
package kee_pkg;

  localparam int DEF_POINT_SLOTS    = 256;
  localparam int DEF_ENVELOPE_SLOTS = 16;

  // shared divider widths
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 24;

  localparam logic [1:0] OP_WR_POINT = 2'd0;
  localparam logic [1:0] OP_WR_ENV   = 2'd1;
  localparam logic [1:0] OP_EVAL     = 2'd2;

  localparam logic [2:0] CURVE_STEP   = 3'd0;
  localparam logic [2:0] CURVE_SLOW   = 3'd2;
  localparam logic [2:0] CURVE_FAST   = 3'd3;
  localparam logic [2:0] CURVE_SMOOTH = 3'd4;

  localparam logic [1:0] CFG_TOTAL_POINTS = 2'd0;
  localparam logic [1:0] CFG_NUM_ENVS     = 2'd1;
  localparam logic [1:0] CFG_TICK_RATE    = 2'd2;

  localparam logic [9:0] TICK_RATE_RESET = 10'd50;

  typedef struct packed {
    logic [23:0]        ktime;
    logic signed [31:0] kx;
    logic signed [31:0] ky;
    logic [2:0]         curve;
  } key_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/kee_if.sv =====
interface kee_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [7:0]         slot_index;
  logic [23:0]        point_time;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic [2:0]         curve_kind;
  logic [7:0]         start_point;
  logic [8:0]         point_count;
  logic signed [4:0]  env_index;
  logic [31:0]        tick_count;
  logic signed [31:0] offset_ms;

  modport source (
    output valid, operation, slot_index, point_time, value_x, value_y, curve_kind,
           start_point, point_count, env_index, tick_count, offset_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, slot_index, point_time, value_x, value_y, curve_kind,
           start_point, point_count, env_index, tick_count, offset_ms,
    output ready
  );
endinterface

interface kee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               is_evaluation;

  modport source (output valid, out_x, out_y, is_evaluation, input ready);
  modport sink (input valid, out_x, out_y, is_evaluation, output ready);
endinterface

// ===== hw/rtl/kee_div.sv =====
module kee_div import kee_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_NW-1:0] quot_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dvs_r;

  logic [DIV_DW:0] trial;
  logic [DIV_DW:0] diff;
  logic            ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, quot_r[DIV_NW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NW);
        quot_r <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        quot_r <= {quot_r[DIV_NW-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/keyframe_envelope_evaluator.sv =====
// one word in flight: a write or rejected evaluation goes from acceptance straight to output,
// a rejected descriptor after its envelope read, a single-point envelope after its point read,
// a full evaluation after up to three shared divider passes, a scan over the points and up to
// five multiplier passes; a zero-length envelope skips the first two divider passes
// a word holds the block until its result is registered, longer while the output is held off
// reset idles the sequencer, clears output valid and the counts, sets tick rate to 50; tables undefined
module keyframe_envelope_evaluator import kee_pkg::*; #(
  parameter int POINT_SLOTS    = DEF_POINT_SLOTS,
  parameter int ENVELOPE_SLOTS = DEF_ENVELOPE_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  kee_in_if.sink     in_ch,
  kee_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata
);

  localparam int PW = $clog2(POINT_SLOTS);
  localparam int EW = (ENVELOPE_SLOTS > 1) ? $clog2(ENVELOPE_SLOTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DESC, S_LAST, S_TGO, S_TW, S_MGO, S_MW, S_SCANRD, S_SCAN0, S_SCAN1,
    S_FGO, S_FW, S_C1, S_C2, S_C3, S_BX, S_BY, S_BE, S_PUT
  } state_t;

  state_t state_r;

  logic [8:0] total_points_r;
  logic [4:0] num_envs_r;
  logic [9:0] tick_rate_r;

  key_t        key_mem [POINT_SLOTS];
  logic [16:0] env_mem [ENVELOPE_SLOTS];
  key_t        key_q;
  logic [16:0] env_q;
  logic [8:0]  rd_addr;

  logic [31:0]        tick_r;
  logic signed [31:0] off_r;
  logic [8:0]         base_r;
  logic [8:0]         last_r;
  logic [8:0]         idx_r;
  key_t               lastk_r;
  key_t               prev_r;
  key_t               cur_r;
  logic [23:0]        t_r;
  logic               neg_r;
  logic [DIV_NW-1:0]  mag_r;
  logic [16:0]        a_r;
  logic signed [53:0] mul_r;
  logic signed [31:0] res_x_r;
  logic signed [31:0] res_y_r;
  logic               res_eval_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r;
  logic signed [31:0] out_y_r;
  logic               out_eval_r;

  logic signed [34:0] mul_a;
  logic signed [18:0] mul_b;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // derived values
  logic [8:0]         tot;
  logic [4:0]         nenv;
  logic [9:0]         tps;
  logic               env_ok;
  logic [7:0]         d_start;
  logic [8:0]         d_cnt;
  logic [9:0]         d_sum;
  logic [8:0]         d_eff;
  logic [8:0]         d_last;
  logic signed [43:0] tms;
  logic [23:0]        wrapped;
  logic [16:0]        cval;
  logic [16:0]        cub;
  logic signed [53:0] badj;
  logic signed [53:0] bq;
  logic               hit;

  assign tot  = (32'(total_points_r) < POINT_SLOTS) ? total_points_r : 9'(POINT_SLOTS);
  assign nenv = (32'(num_envs_r) < ENVELOPE_SLOTS) ? num_envs_r : 5'(ENVELOPE_SLOTS);
  assign tps  = (tick_rate_r == '0) ? 10'd1 : tick_rate_r;
  assign env_ok = !in_ch.env_index[4] && ({1'b0, in_ch.env_index[3:0]} < nenv);

  assign d_start = env_q[7:0];
  assign d_cnt   = env_q[16:8];
  assign d_sum   = {2'b0, d_start} + {1'b0, d_cnt};
  assign d_eff   = (d_sum > {1'b0, tot}) ? tot - {1'b0, d_start} : d_cnt;
  assign d_last  = {1'b0, d_start} + d_eff - 9'd1;

  assign tms     = $signed({2'b0, div_rsp.quot[41:0]}) + 44'(off_r);
  assign wrapped = (neg_r && div_rsp.rem != '0) ? lastk_r.ktime - div_rsp.rem : div_rsp.rem;
  assign hit     = (prev_r.ktime <= t_r) && (t_r < key_q.ktime);

  assign cval = (prev_r.curve == CURVE_FAST) ? 17'd65536 - a_r : a_r;
  assign cub  = mul_r[48:32];

  // truncate toward zero on the divide by 2^16
  assign badj = mul_r + (mul_r[53] ? 54'sd65535 : 54'sd0);
  assign bq   = badj >>> 16;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LAST: begin
        mul_a = $signed({3'b0, tick_r});
        mul_b = 19'sd1000;
      end
      S_C1: begin
        mul_a = $signed({18'b0, cval});
        mul_b = $signed({2'b0, cval});
      end
      S_C2: begin
        mul_a = $signed({1'b0, mul_r[33:0]});
        mul_b = (prev_r.curve == CURVE_SMOOTH) ?
                19'sd196608 - $signed({1'b0, a_r, 1'b0}) : $signed({2'b0, cval});
      end
      S_BX: begin
        mul_a = 35'($signed({cur_r.kx[31], cur_r.kx}) - $signed({prev_r.kx[31], prev_r.kx}));
        mul_b = $signed({2'b0, a_r});
      end
      S_BY: begin
        mul_a = 35'($signed({cur_r.ky[31], cur_r.ky}) - $signed({prev_r.ky[31], prev_r.ky}));
        mul_b = $signed({2'b0, a_r});
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      S_TGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_r[DIV_NW-1:0];
        div_req.divisor  = {14'b0, tps};
      end
      S_MGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag_r;
        div_req.divisor  = lastk_r.ktime;
      end
      S_FGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {4'b0, t_r - prev_r.ktime, 16'b0};
        div_req.divisor  = cur_r.ktime - prev_r.ktime;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_DESC:   rd_addr = d_last;
      S_SCANRD: rd_addr = base_r;
      S_SCAN0:  rd_addr = base_r + 9'd1;
      S_SCAN1:  rd_addr = idx_r + 9'd1;
      default:  rd_addr = last_r;
    endcase
  end

  kee_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // tables
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      if (in_ch.operation == OP_WR_POINT && 32'(in_ch.slot_index) < POINT_SLOTS) begin
        key_mem[PW'(in_ch.slot_index)] <= '{ktime: in_ch.point_time, kx: in_ch.value_x,
                                            ky: in_ch.value_y, curve: in_ch.curve_kind};
      end
      if (in_ch.operation == OP_WR_ENV && 32'(in_ch.slot_index) < ENVELOPE_SLOTS) begin
        env_mem[EW'(in_ch.slot_index)] <= {in_ch.point_count, in_ch.start_point};
      end
    end
    key_q <= key_mem[PW'(rd_addr)];
    env_q <= env_mem[EW'(in_ch.env_index[3:0])];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_points_r <= '0;
      num_envs_r     <= '0;
      tick_rate_r    <= TICK_RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_POINTS: total_points_r <= cfg_wdata[8:0];
        CFG_NUM_ENVS:     num_envs_r     <= cfg_wdata[4:0];
        CFG_TICK_RATE:    tick_rate_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_PUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            res_x_r    <= '0;
            res_y_r    <= '0;
            res_eval_r <= (in_ch.operation == OP_EVAL);
            tick_r     <= in_ch.tick_count;
            off_r      <= in_ch.offset_ms;
            state_r    <= (in_ch.operation == OP_EVAL && env_ok) ? S_DESC : S_PUT;
          end
        end
        S_DESC: begin
          base_r <= {1'b0, d_start};
          last_r <= d_last;
          if (d_cnt == '0 || {1'b0, d_start} >= tot) begin
            state_r <= S_PUT;
          end else begin
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          lastk_r <= key_q;
          if (base_r == last_r) begin
            res_x_r <= key_q.kx;
            res_y_r <= key_q.ky;
            state_r <= S_PUT;
          end else if (key_q.ktime == '0) begin
            t_r     <= '0;
            state_r <= S_SCANRD;
          end else begin
            state_r <= S_TGO;
          end
        end
        S_TGO: state_r <= S_TW;
        S_TW: begin
          if (div_rsp.done) begin
            neg_r   <= tms[43];
            mag_r   <= tms[43] ? DIV_NW'(-tms) : DIV_NW'(tms);
            state_r <= S_MGO;
          end
        end
        S_MGO: state_r <= S_MW;
        S_MW: begin
          if (div_rsp.done) begin
            t_r     <= wrapped;
            state_r <= S_SCANRD;
          end
        end
        S_SCANRD: state_r <= S_SCAN0;
        S_SCAN0: begin
          prev_r  <= key_q;
          idx_r   <= base_r + 9'd1;
          state_r <= S_SCAN1;
        end
        S_SCAN1: begin
          if (hit) begin
            cur_r   <= key_q;
            state_r <= S_FGO;
          end else if (idx_r == last_r) begin
            res_x_r <= lastk_r.kx;
            res_y_r <= lastk_r.ky;
            state_r <= S_PUT;
          end else begin
            prev_r <= key_q;
            idx_r  <= idx_r + 9'd1;
          end
        end
        S_FGO: state_r <= S_FW;
        S_FW: begin
          if (div_rsp.done) begin
            case (prev_r.curve) inside
              CURVE_STEP: begin
                a_r     <= '0;
                state_r <= S_BX;
              end
              CURVE_SLOW, CURVE_FAST, CURVE_SMOOTH: begin
                a_r     <= div_rsp.quot[16:0];
                state_r <= S_C1;
              end
              default: begin
                a_r     <= div_rsp.quot[16:0];
                state_r <= S_BX;
              end
            endcase
          end
        end
        S_C1: state_r <= S_C2;
        S_C2: state_r <= S_C3;
        S_C3: begin
          a_r     <= (prev_r.curve == CURVE_FAST) ? 17'd65536 - cub : cub;
          state_r <= S_BX;
        end
        S_BX: state_r <= S_BY;
        S_BY: begin
          res_x_r <= prev_r.kx + bq[31:0];
          state_r <= S_BE;
        end
        S_BE: begin
          res_y_r <= prev_r.ky + bq[31:0];
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_eval_r  <= res_eval_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = rst_n && (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_x         = out_x_r;
  assign out_ch.out_y         = out_y_r;
  assign out_ch.is_evaluation = out_eval_r;

endmodule
